FILE: rtl/core/mph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mph_pkg
// Shared codes, widths and result type of the MMTP packet header parser.
// ----------------------------------------------------------------------------
package mph_pkg;

  localparam int PhaseW = 3;
  localparam int IdxW   = 4;

  localparam logic [PhaseW-1:0] PH_FIXED   = 3'd0;
  localparam logic [PhaseW-1:0] PH_COUNTER = 3'd1;
  localparam logic [PhaseW-1:0] PH_EXTHDR  = 3'd2;
  localparam logic [PhaseW-1:0] PH_EXTBODY = 3'd3;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd4;

  localparam logic [1:0] K_HEADER = 2'd0;
  localparam logic [1:0] K_EXT    = 2'd1;
  localparam logic [1:0] K_PAY    = 2'd2;
  localparam logic [1:0] K_TRUNC  = 2'd3;

  localparam logic [IdxW-1:0] FIXED_LAST = 4'd11;
  localparam logic [IdxW-1:0] WORD_LAST  = 4'd3;

  localparam int BIT_COUNTER = 5;
  localparam int BIT_EXT     = 1;

  localparam int OutDataW = 168;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  version;
    logic [5:0]  header_flags;
    logic [5:0]  payload_type;
    logic [15:0] packet_id;
    logic [31:0] delivery_timestamp;
    logic [31:0] sequence_number;
    logic [31:0] packet_counter;
    logic [15:0] extension_type;
    logic [15:0] extension_length;
    logic [7:0]  out_byte;
    logic        last_of_packet;
  } res_t;

endpackage

FILE: rtl/core/mph_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mph_in_stage
// Input register holding one packet byte and its end marker.
// ----------------------------------------------------------------------------
module mph_in_stage
  import mph_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tlast,
  input  logic       take,
  output logic       vld,
  output logic [7:0] data_byte,
  output logic       end_of_packet
);

  assign s_tready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      data_byte     <= s_tdata;
      end_of_packet <= s_tlast;
    end
  end

endmodule

FILE: rtl/core/mph_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mph_parser
// Header field collection, phase tracking and result formation.
// ----------------------------------------------------------------------------
module mph_parser
  import mph_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       end_of_packet,
  output logic       has_res,
  output res_t       res
);

  logic [PhaseW-1:0] phase, phase_next;
  logic [IdxW-1:0]   idx, idx_next;
  logic [15:0]       rem, rem_next;
  logic [7:0]        first, first_next;
  logic [5:0]        second, second_next;
  logic [15:0]       pid, pid_next;
  logic [31:0]       ts, ts_next;
  logic [31:0]       seq, seq_next;
  logic [31:0]       ctr, ctr_next;
  logic [15:0]       etype, etype_next;
  logic [15:0]       elen, elen_next;
  logic              clr, finish, trunc;
  logic              has_ctr, has_ext;

  assign has_ctr = first[BIT_COUNTER];
  assign has_ext = first[BIT_EXT];

  always_comb begin
    phase_next  = phase;
    idx_next    = idx;
    rem_next    = rem;
    first_next  = first;
    second_next = second;
    pid_next    = pid;
    ts_next     = ts;
    seq_next    = seq;
    ctr_next    = ctr;
    etype_next  = etype;
    elen_next   = elen;
    clr         = 1'b0;
    finish      = 1'b0;
    trunc       = 1'b0;
    has_res     = 1'b0;
    res         = '0;

    case (phase)
      PH_COUNTER: begin
        ctr_next = {ctr[23:0], data_byte};
        idx_next = idx + 1'b1;
        if (idx == WORD_LAST) begin
          if (has_ext) begin
            idx_next = '0;
            if (end_of_packet) begin
              trunc = 1'b1;
            end else begin
              phase_next = PH_EXTHDR;
            end
          end else begin
            finish = 1'b1;
          end
        end else if (end_of_packet) begin
          trunc = 1'b1;
        end
      end
      PH_EXTHDR: begin
        if (idx[IdxW-1:1] == '0) begin
          etype_next = {etype[7:0], data_byte};
        end else begin
          elen_next = {elen[7:0], data_byte};
        end
        idx_next = idx + 1'b1;
        if (idx == WORD_LAST) begin
          finish = 1'b1;
        end else if (end_of_packet) begin
          trunc = 1'b1;
        end
      end
      PH_EXTBODY: begin
        if (end_of_packet && rem > 16'd1) begin
          trunc = 1'b1;
        end else begin
          has_res            = 1'b1;
          res.result_kind    = K_EXT;
          res.out_byte       = data_byte;
          res.last_of_packet = end_of_packet;
          rem_next           = rem - 16'd1;
          if (end_of_packet) begin
            clr = 1'b1;
          end else if (rem_next == '0) begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        has_res            = 1'b1;
        res.result_kind    = K_PAY;
        res.out_byte       = data_byte;
        res.last_of_packet = end_of_packet;
        clr                = end_of_packet;
      end
      default: begin
        case (idx)
          4'd0: first_next = data_byte;
          4'd1: second_next = data_byte[5:0];
          4'd2, 4'd3: pid_next = {pid[7:0], data_byte};
          4'd4, 4'd5, 4'd6, 4'd7: ts_next = {ts[23:0], data_byte};
          default: seq_next = {seq[23:0], data_byte};
        endcase
        idx_next = idx + 1'b1;
        if (idx == FIXED_LAST) begin
          idx_next = '0;
          if (has_ctr) begin
            if (end_of_packet) begin
              trunc = 1'b1;
            end else begin
              phase_next = PH_COUNTER;
            end
          end else if (has_ext) begin
            if (end_of_packet) begin
              trunc = 1'b1;
            end else begin
              phase_next = PH_EXTHDR;
            end
          end else begin
            finish = 1'b1;
          end
        end else if (end_of_packet) begin
          trunc = 1'b1;
        end
      end
    endcase

    if (finish) begin
      has_res                = 1'b1;
      res.result_kind        = K_HEADER;
      res.version            = first[7:6];
      res.header_flags       = first[5:0];
      res.payload_type       = second_next;
      res.packet_id          = pid_next;
      res.delivery_timestamp = ts_next;
      res.sequence_number    = seq_next;
      res.packet_counter     = has_ctr ? ctr_next : '0;
      res.extension_type     = has_ext ? etype_next : '0;
      res.extension_length   = has_ext ? elen_next : '0;
      res.last_of_packet     = end_of_packet;
      idx_next               = '0;
      rem_next               = has_ext ? elen_next : '0;
      phase_next             = (rem_next != '0) ? PH_EXTBODY : PH_PAYLOAD;
      clr                    = end_of_packet;
    end

    if (trunc) begin
      has_res            = 1'b1;
      res                = '0;
      res.result_kind    = K_TRUNC;
      res.last_of_packet = 1'b1;
      clr                = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIXED;
      idx   <= '0;
      rem   <= '0;
      first <= '0;
    end else if (take) begin
      if (clr) begin
        phase <= PH_FIXED;
        idx   <= '0;
        rem   <= '0;
        first <= '0;
      end else begin
        phase <= phase_next;
        idx   <= idx_next;
        rem   <= rem_next;
        first <= first_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      second <= second_next;
      pid    <= pid_next;
      ts     <= ts_next;
      seq    <= seq_next;
      ctr    <= ctr_next;
      etype  <= etype_next;
      elen   <= elen_next;
    end
  end

endmodule

FILE: rtl/core/mph_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mph_out_stage
// Result register in front of the output stream.
// ----------------------------------------------------------------------------
module mph_out_stage
  import mph_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  logic has_res,
  input  res_t res_in,
  input  logic m_tready,
  output logic free,
  output logic vld,
  output res_t res
);

  assign free = !vld || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= has_res;
    end else if (m_tready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_res) begin
      res <= res_in;
    end
  end

endmodule

FILE: rtl/core/mmtp_packet_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtp_packet_header_parser
// Parses the MMTP fixed header, optional counter and extension header from a
// byte stream, then passes extension and payload bytes through.
//
//   channel  dir  tdata                              tuser        tlast
//   s_*      in   data_byte                          -            end_of_packet
//   m_*      out  header fields, out_byte (168 b)    result_kind  last_of_packet
//
// One byte per cycle sustained while m_tready is high; an input transfer reaches
// its result through the input register, then the result register.
// Bytes that only fill header fields produce no result.
// rst clears both stage valids and returns parsing to the fixed header.
// A stall on m_tready backs up into s_tready through the two registers.
// ----------------------------------------------------------------------------
module mmtp_packet_header_parser
  import mph_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,  // data_byte
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,  // version, header_flags, payload_type,
                                        // packet_id, delivery_timestamp,
                                        // sequence_number, packet_counter,
                                        // extension_type, extension_length,
                                        // out_byte, zero pad
  output logic [1:0]          m_tuser,  // result_kind
  output logic                m_tlast
);

  logic       in_vld, out_free, take, has_res;
  logic [7:0] data_byte;
  logic       end_of_packet;
  res_t       res_c, res_q;

  assign take = in_vld && out_free;

  mph_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .take          (take),
    .vld           (in_vld),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet)
  );

  mph_parser u_parse (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .has_res       (has_res),
    .res           (res_c)
  );

  mph_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .has_res  (has_res),
    .res_in   (res_c),
    .m_tready (m_tready),
    .free     (out_free),
    .vld      (m_tvalid),
    .res      (res_q)
  );

  assign m_tdata = {2'b00, res_q.out_byte, res_q.extension_length, res_q.extension_type,
                    res_q.packet_counter, res_q.sequence_number,
                    res_q.delivery_timestamp, res_q.packet_id, res_q.payload_type,
                    res_q.header_flags, res_q.version};
  assign m_tuser = res_q.result_kind;
  assign m_tlast = res_q.last_of_packet;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MMTP packet header parser. A short table of
// hand-built packets runs first, then random packets (mostly well formed,
// some cut short, some noise) under several flow-control mixes. Every byte
// accepted on s_* goes through a local parser model; each m_* transfer is
// compared in order against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
  import mph_pkg::*;

  localparam int NumRandomBytes = 1850;
  localparam int HoldCycles     = 80;
  localparam int DrainCycles    = 12;
  localparam int CycleLimit     = 400000;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;

  // parser model state
  logic [PhaseW-1:0] phase_st;
  logic [4:0]        hdr_idx;
  logic [15:0]       ext_left;
  logic [7:0]        flags_byte;
  logic [7:0]        ptype_byte;
  logic [15:0]       id_acc;
  logic [31:0]       ts_acc;
  logic [31:0]       seq_acc;
  logic [31:0]       ctr_acc;
  logic [15:0]       etype_acc;
  logic [15:0]       elen_acc;

  res_t     results_due[$];
  dir_row_t dir_rows[$];

  int  errors = 0;
  int  cycles = 0;
  int  bytes_in = 0;
  int  packets_sent = 0;
  int  results_seen = 0;
  int  headers_seen = 0;
  int  truncs_seen = 0;
  int  send_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_go = 1'b0;

  mmtp_packet_header_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, results_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  task automatic clear_parse_state();
    phase_st   = PH_FIXED;
    hdr_idx    = '0;
    ext_left   = '0;
    flags_byte = '0;
    ptype_byte = '0;
    id_acc     = '0;
    ts_acc     = '0;
    seq_acc    = '0;
    ctr_acc    = '0;
    etype_acc  = '0;
    elen_acc   = '0;
  endtask

  function automatic res_t byte_result(input logic [1:0] kind, input logic [7:0] b,
                                       input logic last);
    res_t r;
    r = '0;
    r.result_kind    = kind;
    r.out_byte       = b;
    r.last_of_packet = last;
    return r;
  endfunction

  function automatic res_t header_result(input logic last);
    res_t r;
    r = '0;
    r.result_kind        = K_HEADER;
    r.version            = flags_byte[7:6];
    r.header_flags       = flags_byte[5:0];
    r.payload_type       = ptype_byte[5:0];
    r.packet_id          = id_acc;
    r.delivery_timestamp = ts_acc;
    r.sequence_number    = seq_acc;
    r.packet_counter     = flags_byte[BIT_COUNTER] ? ctr_acc : 32'd0;
    r.extension_type     = flags_byte[BIT_EXT] ? etype_acc : 16'd0;
    r.extension_length   = flags_byte[BIT_EXT] ? elen_acc : 16'd0;
    r.last_of_packet     = last;
    return r;
  endfunction

  task automatic close_header(input logic eop, output res_t r);
    r = header_result(eop);
    hdr_idx = '0;
    if (eop) begin
      clear_parse_state();
    end else begin
      ext_left = flags_byte[BIT_EXT] ? elen_acc : 16'd0;
      phase_st = (ext_left != 16'd0) ? PH_EXTBODY : PH_PAYLOAD;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eop, output bit emit,
                            output res_t r);
    bit done;
    emit = 1'b0;
    done = 1'b0;
    r = '0;
    case (phase_st)
      PH_COUNTER: begin
        ctr_acc = {ctr_acc[23:0], b};
        hdr_idx = hdr_idx + 5'd1;
        if (hdr_idx >= 5'd4) begin
          done = 1'b1;
          if (!flags_byte[BIT_EXT]) begin
            close_header(eop, r);
            emit = 1'b1;
          end else if (eop) begin
            clear_parse_state();
            r = byte_result(K_TRUNC, 8'd0, 1'b1);
            emit = 1'b1;
          end else begin
            phase_st = PH_EXTHDR;
            hdr_idx = '0;
          end
        end
      end
      PH_EXTHDR: begin
        if (hdr_idx < 5'd2) etype_acc = {etype_acc[7:0], b};
        else elen_acc = {elen_acc[7:0], b};
        hdr_idx = hdr_idx + 5'd1;
        if (hdr_idx >= 5'd4) begin
          close_header(eop, r);
          emit = 1'b1;
          done = 1'b1;
        end
      end
      PH_EXTBODY: begin
        done = 1'b1;
        emit = 1'b1;
        if (eop && ext_left > 16'd1) begin
          clear_parse_state();
          r = byte_result(K_TRUNC, 8'd0, 1'b1);
        end else begin
          r = byte_result(K_EXT, b, eop);
          ext_left = ext_left - 16'd1;
          if (eop) clear_parse_state();
          else if (ext_left == 16'd0) phase_st = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        done = 1'b1;
        emit = 1'b1;
        r = byte_result(K_PAY, b, eop);
        if (eop) clear_parse_state();
      end
      default: begin
        if (phase_st != PH_FIXED) clear_parse_state();
        case (hdr_idx)
          5'd0: flags_byte = b;
          5'd1: ptype_byte = b;
          5'd2, 5'd3: id_acc = {id_acc[7:0], b};
          5'd4, 5'd5, 5'd6, 5'd7: ts_acc = {ts_acc[23:0], b};
          default: seq_acc = {seq_acc[23:0], b};
        endcase
        hdr_idx = hdr_idx + 5'd1;
        if (hdr_idx >= 5'd12) begin
          hdr_idx = '0;
          done = 1'b1;
          if (flags_byte[BIT_COUNTER] || flags_byte[BIT_EXT]) begin
            if (eop) begin
              clear_parse_state();
              r = byte_result(K_TRUNC, 8'd0, 1'b1);
              emit = 1'b1;
            end else begin
              phase_st = flags_byte[BIT_COUNTER] ? PH_COUNTER : PH_EXTHDR;
            end
          end else begin
            close_header(eop, r);
            emit = 1'b1;
          end
        end
      end
    endcase
    if (!done && eop) begin
      clear_parse_state();
      r = byte_result(K_TRUNC, 8'd0, 1'b1);
      emit = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b, input logic l, input bit use_fixed,
                           input res_t fixed_res);
    bit   emit;
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_byte(b, l, emit, r);
    if (use_fixed) results_due.push_back(fixed_res);
    else if (emit) results_due.push_back(r);
    bytes_in++;
    if (l) packets_sent++;
  endtask

  task automatic send_random_packet();
    logic [7:0] pkt[$];
    logic [7:0] b0;
    logic [15:0] elen;
    int body_n;
    int pay_n;
    int n;
    int pick;
    bit forced_cut;
    forced_cut = 1'b0;
    if ($urandom_range(99) < 5) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        send_byte(8'($urandom_range(255)),
                  (i == n - 1) ? 1'b1 : 1'($urandom_range(1)), 1'b0, '0);
      end
      return;
    end
    b0 = 8'($urandom_range(255));
    pkt.push_back(b0);
    for (int i = 0; i < 11; i++) pkt.push_back(8'($urandom_range(255)));
    if (b0[BIT_COUNTER]) begin
      for (int i = 0; i < 4; i++) pkt.push_back(8'($urandom_range(255)));
    end
    if (b0[BIT_EXT]) begin
      pick = $urandom_range(99);
      if (pick < 35) elen = 16'($urandom_range(0, 4));
      else if (pick < 70) elen = 16'($urandom_range(5, 12));
      else elen = 16'($urandom_range(65535));
      pkt.push_back(8'($urandom_range(255)));
      pkt.push_back(8'($urandom_range(255)));
      pkt.push_back(elen[15:8]);
      pkt.push_back(elen[7:0]);
      body_n = int'(elen);
      // long extensions are only started, then cut short
      if (elen > 16'd24) begin
        body_n = $urandom_range(0, 6);
        forced_cut = 1'b1;
      end
      for (int i = 0; i < body_n; i++) pkt.push_back(8'($urandom_range(255)));
    end
    if (!forced_cut) begin
      pay_n = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 40);
      for (int i = 0; i < pay_n; i++) pkt.push_back(8'($urandom_range(255)));
    end
    n = pkt.size();
    if (!forced_cut && $urandom_range(99) < 15) n = $urandom_range(1, pkt.size());
    for (int i = 0; i < n; i++) send_byte(pkt[i], (i == n - 1), 1'b0, '0);
  endtask

  task automatic add_row(input logic [7:0] d, input logic l, input bit typed, input res_t w);
    dir_row_t row;
    row.data  = d;
    row.last  = l;
    row.typed = typed;
    row.want  = w;
    dir_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (HoldCycles) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic res_t unpack_result();
    res_t g;
    g = '0;
    g.result_kind        = m_tuser;
    g.version            = m_tdata[0 +: 2];
    g.header_flags       = m_tdata[2 +: 6];
    g.payload_type       = m_tdata[8 +: 6];
    g.packet_id          = m_tdata[14 +: 16];
    g.delivery_timestamp = m_tdata[30 +: 32];
    g.sequence_number    = m_tdata[62 +: 32];
    g.packet_counter     = m_tdata[94 +: 32];
    g.extension_type     = m_tdata[126 +: 16];
    g.extension_length   = m_tdata[142 +: 16];
    g.out_byte           = m_tdata[158 +: 8];
    g.last_of_packet     = m_tlast;
    return g;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got = unpack_result();
      results_seen++;
      if (got.result_kind == K_HEADER) headers_seen++;
      if (got.result_kind == K_TRUNC) truncs_seen++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: %h", got);
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch on result %0d (kind exp %0d got %0d)",
                     results_seen, want.result_kind, got.result_kind);
            $display("  exp %h", want);
            $display("  got %h", got);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    res_t hdr_ext;
    int target;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    clear_parse_state();

    // lone final byte: truncated in header
    add_row(8'h00, 1'b1, 1'b1, byte_result(K_TRUNC, 8'd0, 1'b1));
    // fixed header only, all-ones fields after the flags byte, header ends the packet
    hdr_ext = '0;
    hdr_ext.result_kind        = K_HEADER;
    hdr_ext.version            = 2'd3;
    hdr_ext.header_flags       = 6'h1D;
    hdr_ext.payload_type       = 6'h3F;
    hdr_ext.packet_id          = 16'hFFFF;
    hdr_ext.delivery_timestamp = 32'hFFFF_FFFF;
    hdr_ext.sequence_number    = 32'hFFFF_FFFF;
    hdr_ext.last_of_packet     = 1'b1;
    add_row(8'hDD, 1'b0, 1'b0, '0);
    for (int i = 0; i < 10; i++) add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, hdr_ext);
    // extension flag, zero fields, one extension byte then one payload byte
    add_row(8'h02, 1'b0, 1'b0, '0);
    for (int i = 0; i < 11; i++) add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b0, 1'b0, '0);
    add_row(8'hA5, 1'b1, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (results_due.size() != 0);
      case (ph)
        0: begin
          send_idle_pct = 0;
          rx_stall_pct  = 0;
        end
        1: begin
          send_idle_pct = 48;
          rx_stall_pct  = 0;
        end
        2: begin
          send_idle_pct = 0;
          rx_stall_pct  = 48;
        end
        default: begin
          send_idle_pct = 23;
          rx_stall_pct  = 23;
        end
      endcase
      target = dir_rows.size() + (ph + 1) * NumRandomBytes / 4;
      while (bytes_in < target) begin
        // long receiver hold while bytes keep coming
        if (ph == 0 && bytes_in >= target / 2 && bytes_in < target / 2 + 40) hold_go = 1'b1;
        send_random_packet();
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("run: %0d packets, %0d bytes in, %0d results out", packets_sent, bytes_in,
             results_seen);
    $display("     %0d headers, %0d truncations, %0d mismatches, %0d cycles", headers_seen,
             truncs_seen, errors, cycles);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
